/* design/itoa_pkg.sv */
// Shared constants, types and the digit-to-character function for the radix converter.
package itoa_pkg;

  // Field and register widths.
  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int RADIX_W          = 6;
  localparam int CHAR_W           = 7;
  localparam int CFG_ADDR_W       = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_RADIX      = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPPER_CASE = 1'b1;

  // Radix limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Dividend bits consumed by the divider in one cycle.
  localparam int DIV_STEP = 8;

  // Character constants.
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_LOWER_A  = 7'h61;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new number, clear the digit count
    logic step;   // run one chunk of the long division
    logic push;   // this step finishes a digit: store the remainder
    logic pop;    // read out the most significant stored digit
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;   // the running quotient is zero
    logic have_digit;  // at least one digit is stored
    logic one_left;    // exactly one digit is stored
  } ctrl_status_t;

  // Map a digit value to its ASCII code.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit,
                                                       input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (digit < DECIMAL_DIGITS) begin
      return ASCII_ZERO + CHAR_W'(digit);
    end
    return letter_base + CHAR_W'(digit - DECIMAL_DIGITS);
  endfunction

endpackage

/* design/itoa_ctrl.sv */
// Controller state machine that sequences division, digit storage and output.
module itoa_ctrl #(
  parameter int NUMBER_WIDTH = itoa_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  itoa_pkg::ctrl_status_t status_i,
  output itoa_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);
  import itoa_pkg::*;

  localparam int CHUNKS  = (NUMBER_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    chunk_d = chunk_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          chunk_d    = '0;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // At a digit boundary a zero quotient ends the conversion.
        if (chunk_q == '0 && status_i.have_digit && status_i.quot_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
          cmd_o.push = (chunk_q == LAST_CHUNK);
          chunk_d    = (chunk_q == LAST_CHUNK) ? '0 : chunk_q + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.pop = 1'b1;
        if (status_i.one_left) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chunk_q <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* design/itoa_datapath.sv */
// Datapath: configuration registers, chunked long divider, digit stack and output register.
module itoa_datapath #(
  parameter int NUMBER_WIDTH = itoa_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [itoa_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [itoa_pkg::RADIX_W-1:0]        cfg_wdata_i,
  input  logic [NUMBER_WIDTH-1:0]             number_i,
  input  itoa_pkg::ctrl_cmd_t                 cmd_i,
  output itoa_pkg::ctrl_status_t              status_o,
  output logic                                out_valid_o,
  output logic [itoa_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o
);
  import itoa_pkg::*;

  localparam int CHUNKS = (NUMBER_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W  = CHUNKS * DIV_STEP;
  localparam int ADDR_W = $clog2(NUMBER_WIDTH);
  localparam int CNT_W  = $clog2(NUMBER_WIDTH + 1);

  logic [RADIX_W-1:0] radix_q;
  logic               upper_q;
  logic [DIV_W-1:0]   val_q, val_next;
  logic [RADIX_W-1:0] rem_q, rem_next;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_dec;
  logic [RADIX_W-1:0] digit_mem [NUMBER_WIDTH];
  logic [RADIX_W-1:0] rd_q;
  logic               out_valid_q;
  logic               last_q;

  // Configuration registers; the radix is clamped to its legal range when written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RADIX: begin
          if (cfg_wdata_i < RADIX_MIN) begin
            radix_q <= RADIX_MIN;
          end else if (cfg_wdata_i > RADIX_MAX) begin
            radix_q <= RADIX_MAX;
          end else begin
            radix_q <= cfg_wdata_i;
          end
        end
        REG_UPPER_CASE: begin
          upper_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // One chunk of restoring division: quotient bits shift in as dividend bits shift out.
  always_comb begin
    logic [RADIX_W:0] trial;
    val_next = val_q;
    rem_next = rem_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {rem_next, val_next[DIV_W-1]};
      val_next = {val_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        rem_next    = RADIX_W'(trial - {1'b0, radix_q});
        val_next[0] = 1'b1;
      end else begin
        rem_next = trial[RADIX_W-1:0];
      end
    end
  end

  assign cnt_dec = cnt_q - 1'b1;

  // Division and digit count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= cmd_i.push ? '0 : rem_next;
      if (cmd_i.push) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_dec;
    end
  end

  // Dividend register holds the running quotient.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= DIV_W'(number_i);
    end else if (cmd_i.step) begin
      val_q <= val_next;
    end
  end

  // Digit stack: written least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cmd_i.push) begin
      digit_mem[cnt_q[ADDR_W-1:0]] <= rem_next;
    end
    if (cmd_i.pop) begin
      rd_q   <= digit_mem[cnt_dec[ADDR_W-1:0]];
      last_q <= (cnt_q == CNT_W'(1));
    end
  end

  // Output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.pop;
    end
  end

  assign status_o.quot_zero  = (val_q == '0);
  assign status_o.have_digit = (cnt_q != '0);
  assign status_o.one_left   = (cnt_q == CNT_W'(1));

  assign out_valid_o = out_valid_q;
  assign character_o = digit_to_ascii(rd_q, upper_q);
  assign last_o      = last_q;

endmodule

/* design/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter in a configurable radix.
//
// A number is requested by raising start_i while busy_o is low; number_i is
// taken at that edge. The block then emits the digits in the configured
// radix (2 to 36), most significant first, one ASCII character per
// out_valid_o pulse on character_o, with last_o high on the final digit.
// Zero gives a single '0'. Each character is shown for exactly one cycle;
// the receiver cannot stall the block and must take it.
// Registers are written on cfg_we_i with cfg_addr_i: index 0 is the radix
// (values outside 2..36 are clamped), index 1 selects upper case letters.
// Write them only while the block is idle.
// Operation: a long divider takes 8 dividend bits per cycle and stores one
// remainder digit per pass over the whole dividend; a zero quotient at a
// digit boundary ends the division, then the digit stack is read out. The
// last character appears in the first cycle that busy_o is low again.
// Reset sets the radix to 10 and lower case letters and aborts any request.
module integer_to_ascii_radix #(
  parameter int NUMBER_WIDTH = itoa_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [itoa_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [itoa_pkg::RADIX_W-1:0]    cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [NUMBER_WIDTH-1:0]         number_i,
  output logic                            out_valid_o,
  output logic [itoa_pkg::CHAR_W-1:0]     character_o,
  output logic                            last_o
);
  import itoa_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  itoa_ctrl #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Divider, digit stack and output.
  itoa_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .number_i   (number_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  // A new number is only loaded when the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.load |-> !busy_o)
    else $error("number loaded while busy");

  // The divider and the digit readout never run in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.step && cmd.pop))
    else $error("division step and digit readout overlap");

  // Every character comes from a request that was in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> $past(busy_o))
    else $error("character emitted without a request");

  // The final character of a number is not followed directly by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && last_o) |=> !out_valid_o)
    else $error("character emitted right after the last one");

endmodule
